@@ rtl/core/timed_integer_pid_top_assert.svh @@
// Assertion macros for the timed integer PID block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef TIMED_INTEGER_PID_TOP_ASSERT_SVH
`define TIMED_INTEGER_PID_TOP_ASSERT_SVH

// same-cycle implication
`define TIPID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed_integer_pid assertion failed");

// next-cycle implication
`define TIPID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed_integer_pid assertion failed");

`endif

@@ rtl/core/tipid_pkg.sv @@
// Shared types and constants of the timed integer PID block.
// Used by the serial multiplier, the serial divider and the top level.
package tipid_pkg;

    localparam int DATA_W           = 32;
    localparam int STAMP_W          = 63;
    localparam int DIVISOR_W        = 31;
    localparam int TICKS_PER_MS     = 1000;
    localparam int DERIV_SCALE      = 1000;

    localparam int MUL_ITERS        = 32;
    localparam int MUL_CNT_W        = 5;
    localparam int DIV_WIDE_ITERS   = 63;
    localparam int DIV_NARROW_ITERS = 32;
    localparam int DIV_CNT_W        = 6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FIRST = 2'd1,
        ST_STALE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_SCALE      = 3'd3,
        REG_OUT_MIN    = 3'd4,
        REG_OUT_MAX    = 3'd5,
        REG_TARGET     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic start;
        logic wide;
    } div_ctl_t;

endpackage

@@ rtl/core/tipid_mul.sv @@
// Serial shift-add multiplier, one multiplier bit per cycle, low 32 bits kept.
// Depends on tipid_pkg.
module tipid_mul
    import tipid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] prod
);

    logic [DATA_W-1:0]    a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[DATA_W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/core/tipid_div.sv @@
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// 63-bit or 32-bit dividend (left aligned), 31-bit divisor. Depends on tipid_pkg.
module tipid_div
    import tipid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctl_t             ctl,
    input  logic [STAMP_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DATA_W-1:0]    quotient
);

    logic [STAMP_W-1:0]   num_reg, num_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0] last_reg, last_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, num_reg[STAMP_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            last_next = ctl.wide ? DIV_CNT_W'(DIV_WIDE_ITERS - 1)
                                 : DIV_CNT_W'(DIV_NARROW_ITERS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            num_next = {num_reg[STAMP_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == last_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/timed_integer_pid_top.sv @@
// Timed integer PID regulator: top level with configuration, sequencer and output register.
// Depends on tipid_pkg, tipid_mul, tipid_div and timed_integer_pid_top_assert.svh.
//
// One item is worked at a time. A restart item gives no result and leaves the block ready.
// A first sample or a sample whose time has not advanced goes straight to the push state,
// which loads its result into the output register once that register is free. A computed
// sample passes through the whole sequence: the serial divider first forms the millisecond
// count (the proportional product runs beside it), the serial multiplier then forms four
// products in turn, and the same divider forms the derivative quotient (skipped when the
// millisecond count is not positive) and the final scaling, before the clamp and push states.
// The block is ready for the next item as soon as the result enters the output register;
// a result still held there by the receiver delays it further.
`include "timed_integer_pid_top_assert.svh"

module timed_integer_pid_top
    import tipid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // measured_speed [31:0], timestamp_us [94:32], zero [95]
    input  logic        s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive [31:0]
    output logic [1:0]  m_tuser    // status [1:0]
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_MS     = 12'b000000000010,
        S_ESUM   = 12'b000000000100,
        S_ITERM  = 12'b000000001000,
        S_DMUL   = 12'b000000010000,
        S_DSCALE = 12'b000000100000,
        S_DDIV   = 12'b000001000000,
        S_SUM    = 12'b000010000000,
        S_SSTART = 12'b000100000000,
        S_SDIV   = 12'b001000000000,
        S_CLAMP  = 12'b010000000000,
        S_PUSH   = 12'b100000000000
    } state_t;

    logic [DATA_W-1:0]    gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DIVISOR_W-1:0] scale_reg;
    logic [DATA_W-1:0]    out_min_reg, out_max_reg, target_reg;

    state_t               state_reg, state_next;
    logic [DATA_W-1:0]    err_reg, err_next;
    logic [DATA_W-1:0]    last_err_reg, last_err_next;
    logic [DATA_W-1:0]    esum_reg, esum_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic                 await_reg, await_next;
    logic [DATA_W-1:0]    ms_reg, ms_next;
    logic [DATA_W-1:0]    p_reg, p_next;
    logic [DATA_W-1:0]    i_reg, i_next;
    logic [DATA_W-1:0]    d_reg, d_next;
    logic [DATA_W-1:0]    work_reg, work_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    res_drive_reg, res_drive_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_drive_reg, out_drive_next;
    status_t              out_status_reg, out_status_next;

    logic [DATA_W-1:0]    in_meas;
    logic [STAMP_W-1:0]   in_now;
    logic [DATA_W-1:0]    in_err;
    logic [STAMP_W-1:0]   dt;
    logic                 accept;
    logic                 ms_pos;
    logic [DATA_W-1:0]    esum_add;
    logic [DATA_W-1:0]    prod_abs;
    logic [DATA_W-1:0]    work_abs;
    logic [DATA_W-1:0]    quo_signed;
    logic [DATA_W-1:0]    clamp_hi;
    logic [DIVISOR_W-1:0] den;

    logic                 mul_start;
    logic [DATA_W-1:0]    mul_a, mul_b;
    logic                 mul_done;
    logic [DATA_W-1:0]    mul_prod;
    div_ctl_t             div_ctl;
    logic [STAMP_W-1:0]   div_num;
    logic [DIVISOR_W-1:0] div_den;
    logic                 div_done;
    logic [DATA_W-1:0]    div_quo;

    assign in_meas    = s_tdata[31:0];
    assign in_now     = s_tdata[94:32];
    assign in_err     = target_reg - in_meas;
    assign dt         = in_now - stamp_reg;
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign ms_pos     = !ms_reg[DATA_W-1] && (ms_reg != '0);
    assign esum_add   = esum_reg + mul_prod;
    assign prod_abs   = mul_prod[DATA_W-1] ? (~mul_prod + 1'b1) : mul_prod;
    assign work_abs   = work_reg[DATA_W-1] ? (~work_reg + 1'b1) : work_reg;
    assign quo_signed = neg_reg ? (~div_quo + 1'b1) : div_quo;
    assign clamp_hi   = ($signed(work_reg) > $signed(out_max_reg)) ? out_max_reg : work_reg;
    assign den        = (scale_reg == '0) ? DIVISOR_W'(1) : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            scale_reg   <= DIVISOR_W'(1);
            out_min_reg <= '0;
            out_max_reg <= DATA_W'(255);
            target_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:  gain_p_reg  <= cfg_data;
                REG_GAIN_I:  gain_i_reg  <= cfg_data;
                REG_GAIN_D:  gain_d_reg  <= cfg_data;
                REG_SCALE:   scale_reg   <= cfg_data[DIVISOR_W-1:0];
                REG_OUT_MIN: out_min_reg <= cfg_data;
                REG_OUT_MAX: out_max_reg <= cfg_data;
                REG_TARGET:  target_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        err_next        = err_reg;
        last_err_next   = last_err_reg;
        esum_next       = esum_reg;
        stamp_next      = stamp_reg;
        await_next      = await_reg;
        ms_next         = ms_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        d_next          = d_reg;
        work_next       = work_reg;
        neg_next        = neg_reg;
        res_drive_next  = res_drive_reg;
        res_status_next = res_status_reg;
        mul_start       = 1'b0;
        mul_a           = err_reg;
        mul_b           = ms_reg;
        div_ctl.start   = 1'b0;
        div_ctl.wide    = 1'b0;
        div_num         = {work_abs, {(STAMP_W-DATA_W){1'b0}}};
        div_den         = den;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_next = in_err;
                    if (s_tuser)
                    begin
                        esum_next     = '0;
                        last_err_next = '0;
                        await_next    = 1'b1;
                    end
                    else if (await_reg)
                    begin
                        stamp_next      = in_now;
                        last_err_next   = in_err;
                        await_next      = 1'b0;
                        res_drive_next  = '0;
                        res_status_next = ST_FIRST;
                        state_next      = S_PUSH;
                    end
                    else if (in_now <= stamp_reg)
                    begin
                        res_drive_next  = '0;
                        res_status_next = ST_STALE;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        stamp_next    = in_now;
                        div_ctl.start = 1'b1;
                        div_ctl.wide  = 1'b1;
                        div_num       = dt;
                        div_den       = DIVISOR_W'(TICKS_PER_MS);
                        mul_start     = 1'b1;
                        mul_a         = gain_p_reg;
                        mul_b         = in_err;
                        state_next    = S_MS;
                    end
                end
            end
            S_MS:
            begin
                if (mul_done)
                begin
                    p_next = mul_prod;
                end
                if (div_done)
                begin
                    ms_next    = div_quo;
                    mul_start  = 1'b1;
                    mul_a      = err_reg;
                    mul_b      = div_quo;
                    state_next = S_ESUM;
                end
            end
            S_ESUM:
            begin
                if (mul_done)
                begin
                    esum_next  = esum_add;
                    mul_start  = 1'b1;
                    mul_a      = gain_i_reg;
                    mul_b      = esum_add;
                    state_next = S_ITERM;
                end
            end
            S_ITERM:
            begin
                if (mul_done)
                begin
                    i_next        = mul_prod;
                    mul_start     = 1'b1;
                    mul_a         = gain_d_reg;
                    mul_b         = err_reg - last_err_reg;
                    last_err_next = err_reg;
                    state_next    = S_DMUL;
                end
            end
            S_DMUL:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = DATA_W'(DERIV_SCALE);
                    state_next = S_DSCALE;
                end
            end
            S_DSCALE:
            begin
                if (mul_done)
                begin
                    if (ms_pos)
                    begin
                        neg_next      = mul_prod[DATA_W-1];
                        div_ctl.start = 1'b1;
                        div_num       = {prod_abs, {(STAMP_W-DATA_W){1'b0}}};
                        div_den       = ms_reg[DIVISOR_W-1:0];
                        state_next    = S_DDIV;
                    end
                    else
                    begin
                        d_next     = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    d_next     = quo_signed;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                work_next  = p_reg + i_reg + d_reg;
                state_next = S_SSTART;
            end
            S_SSTART:
            begin
                neg_next      = work_reg[DATA_W-1];
                div_ctl.start = 1'b1;
                state_next    = S_SDIV;
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    work_next  = quo_signed;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                res_drive_next  = ($signed(clamp_hi) < $signed(out_min_reg)) ? out_min_reg
                                                                              : clamp_hi;
                res_status_next = ST_OK;
                state_next      = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_drive_next  = out_drive_reg;
        out_status_next = out_status_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_PUSH) && (!out_valid_reg || m_tready))
        begin
            out_valid_next  = 1'b1;
            out_drive_next  = res_drive_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            esum_reg      <= '0;
            last_err_reg  <= '0;
            stamp_reg     <= '0;
            await_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esum_reg      <= esum_next;
            last_err_reg  <= last_err_next;
            stamp_reg     <= stamp_next;
            await_reg     <= await_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        ms_reg         <= ms_next;
        p_reg          <= p_next;
        i_reg          <= i_next;
        d_reg          <= d_next;
        work_reg       <= work_next;
        neg_reg        <= neg_next;
        res_drive_reg  <= res_drive_next;
        res_status_reg <= res_status_next;
        out_drive_reg  <= out_drive_next;
        out_status_reg <= out_status_next;
    end

    tipid_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tipid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_status_reg;

    `TIPID_ASSERT_IMP(a_idle_result_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `TIPID_ASSERT_IMP(a_mul_done_state, mul_done,
        (state_reg == S_MS) || (state_reg == S_ESUM) || (state_reg == S_ITERM) ||
        (state_reg == S_DMUL) || (state_reg == S_DSCALE))
    `TIPID_ASSERT_IMP(a_div_done_state, div_done,
        (state_reg == S_MS) || (state_reg == S_DDIV) || (state_reg == S_SDIV))
    `TIPID_ASSERT_NXT(a_restart_clears, accept && s_tuser,
        await_reg && (state_reg == S_IDLE) && (esum_reg == '0) && (last_err_reg == '0))

endmodule

@@ sim/timed_integer_pid_checker.sv @@
// Checker for the timed integer PID block: follows register writes and sample items,
// predicts drive and status for each accepted item that gives a result and compares them with the result channel.
// Depends on tipid_pkg for the status codes and register indexes.
module timed_integer_pid_checker
    import tipid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // measured_speed [31:0], timestamp_us [94:32], zero [95]
    input  logic        s_tuser,   // mode [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // drive [31:0]
    input  logic [1:0]  m_tuser,   // status [1:0]
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [31:0] drive;
        status_t     status;
    } pid_result_t;

    int          kp;
    int          ki;
    int          kd;
    logic [30:0] scale;
    int          out_lo;
    int          out_hi;
    int          setpoint;

    int          integ_acc;
    int          prev_error;
    logic [62:0] prev_stamp;
    logic        first_due;

    pid_result_t drive_due [$];
    int          fails = 0;
    int          checked_n = 0;

    function automatic void reset_model();
        kp         = 0;
        ki         = 0;
        kd         = 0;
        scale      = 31'd1;
        out_lo     = 0;
        out_hi     = 255;
        setpoint   = 0;
        integ_acc  = 0;
        prev_error = 0;
        prev_stamp = '0;
        first_due  = 1'b1;
    endfunction

    function automatic logic advance_loop(input logic restart, input int meas,
                                          input logic [62:0] now, output pid_result_t res);
        int          err;
        int          pterm;
        int          iterm;
        int          dterm;
        int          total;
        int          den;
        int          ms;
        int          drive;
        logic [62:0] dt;
        logic [62:0] quo;
        res = '0;
        if (restart)
        begin
            integ_acc  = 0;
            prev_error = 0;
            first_due  = 1'b1;
            return 1'b0;
        end
        err = setpoint - meas;
        if (first_due)
        begin
            prev_stamp = now;
            prev_error = err;
            first_due  = 1'b0;
            res.status = ST_FIRST;
            return 1'b1;
        end
        if (now <= prev_stamp)
        begin
            res.status = ST_STALE;
            return 1'b1;
        end
        dt        = now - prev_stamp;
        pterm     = kp * err;
        quo       = dt / 63'(TICKS_PER_MS);
        ms        = $signed(quo[31:0]);
        integ_acc = integ_acc + err * ms;
        iterm     = ki * integ_acc;
        dterm     = 0;
        if (ms > 0)
            dterm = (kd * (err - prev_error) * DERIV_SCALE) / ms;
        total = pterm + iterm + dterm;
        den   = (scale == '0) ? 1 : $signed({1'b0, scale});
        drive = total / den;
        if (drive > out_hi)
            drive = out_hi;
        if (drive < out_lo)
            drive = out_lo;
        prev_error = err;
        prev_stamp = now;
        res.drive  = drive;
        res.status = ST_OK;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        pid_result_t want;
        pid_result_t got;
        if (!rst_n)
        begin
            reset_model();
            drive_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:  kp       = cfg_data;
                    REG_GAIN_I:  ki       = cfg_data;
                    REG_GAIN_D:  kd       = cfg_data;
                    REG_SCALE:   scale    = cfg_data[30:0];
                    REG_OUT_MIN: out_lo   = cfg_data;
                    REG_OUT_MAX: out_hi   = cfg_data;
                    REG_TARGET:  setpoint = cfg_data;
                    default:     ;
                endcase
            end
            // take the result before the item of the same edge
            if (m_tvalid && m_tready)
            begin
                if (drive_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result drive %0d status %0d", $time,
                             $signed(m_tdata), m_tuser);
                end
                else
                begin
                    want = drive_due.pop_front();
                    checked_n++;
                    if (m_tdata !== want.drive)
                    begin
                        fails++;
                        $display("%0t: drive expected %0d actual %0d", $time,
                                 $signed(want.drive), $signed(m_tdata));
                    end
                    if (m_tuser !== want.status)
                    begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (advance_loop(s_tuser, s_tdata[31:0], s_tdata[94:32], got))
                    drive_due.push_back(got);
            end
        end
        fail_count <= fails;
        pending    <= drive_due.size();
        checked    <= checked_n;
    end

endmodule

@@ sim/tb_timed_integer_pid_top.sv @@
// Testbench top for the timed integer PID block: clock, reset, register settings and
// sample items under several handshake profiles; verdict from timed_integer_pid_checker.
// Depends on tipid_pkg, timed_integer_pid_top and timed_integer_pid_checker.
module tb_timed_integer_pid_top;
    import tipid_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE_ITEMS  = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // measured_speed [31:0], timestamp_us [94:32], zero [95]
    logic        s_tuser   = 1'b0; // mode [0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // drive [31:0]
    logic [1:0]  m_tuser;          // status [1:0]

    int          fail_count;
    int          pending;
    int          checked;

    int          send_idle  = 0;
    int          recv_stall = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          restarts   = 0;
    int          settings   = 0;
    logic [31:0] reg_vals [7];
    logic [62:0] t;

    timed_integer_pid_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    timed_integer_pid_checker pid_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic restart, input logic [31:0] meas,
                             input logic [62:0] stamp);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, stamp, meas};
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (restart)
            restarts++;
    endtask

    // hold the sender until every result is in and the block has gone quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_setting(input int which);
        case (which)
            0:
            begin
                reg_vals[REG_GAIN_P]  = 32'd2;
                reg_vals[REG_GAIN_I]  = 32'd1;
                reg_vals[REG_GAIN_D]  = 32'd1;
                reg_vals[REG_SCALE]   = 32'd4;
                reg_vals[REG_OUT_MIN] = -32'sd1000;
                reg_vals[REG_OUT_MAX] = 32'd1000;
                reg_vals[REG_TARGET]  = 32'd500;
            end
            1:
            begin
                reg_vals[REG_GAIN_P]  = 32'h7FFF_FFFF;
                reg_vals[REG_GAIN_I]  = 32'h8000_0000;
                reg_vals[REG_GAIN_D]  = 32'hFFFF_FFFF;
                reg_vals[REG_SCALE]   = 32'h7FFF_FFFF;
                reg_vals[REG_OUT_MIN] = 32'h8000_0000;
                reg_vals[REG_OUT_MAX] = 32'h7FFF_FFFF;
                reg_vals[REG_TARGET]  = 32'h8000_0000;
            end
            2:
            begin
                // zero divisor and crossed limits
                reg_vals[REG_GAIN_P]  = -32'sd3;
                reg_vals[REG_GAIN_I]  = 32'd7;
                reg_vals[REG_GAIN_D]  = 32'd5;
                reg_vals[REG_SCALE]   = 32'd0;
                reg_vals[REG_OUT_MIN] = 32'd100;
                reg_vals[REG_OUT_MAX] = -32'sd100;
                reg_vals[REG_TARGET]  = 32'd0;
            end
            3:
            begin
                reg_vals[REG_GAIN_P]  = 32'd1;
                reg_vals[REG_GAIN_I]  = 32'd0;
                reg_vals[REG_GAIN_D]  = 32'd0;
                reg_vals[REG_SCALE]   = 32'd1;
                reg_vals[REG_OUT_MIN] = 32'h8000_0000;
                reg_vals[REG_OUT_MAX] = 32'h7FFF_FFFF;
                reg_vals[REG_TARGET]  = 32'h7FFF_FFFF;
            end
            default:
            begin
                reg_vals[REG_GAIN_P] = ($urandom_range(3) == 0) ? $urandom
                                                                : $urandom_range(200) - 100;
                reg_vals[REG_GAIN_I] = ($urandom_range(3) == 0) ? $urandom
                                                                : $urandom_range(20) - 10;
                reg_vals[REG_GAIN_D] = ($urandom_range(3) == 0) ? $urandom
                                                                : $urandom_range(20) - 10;
                case ($urandom_range(9))
                    0:       reg_vals[REG_SCALE] = 32'd0;
                    1:       reg_vals[REG_SCALE] = $urandom;
                    default: reg_vals[REG_SCALE] = $urandom_range(64, 1);
                endcase
                reg_vals[REG_OUT_MIN] = 32'd0 - $urandom_range(5000);
                reg_vals[REG_OUT_MAX] = $urandom_range(5000);
                if ($urandom_range(9) == 0)
                begin
                    reg_vals[REG_OUT_MIN] = $urandom;
                    reg_vals[REG_OUT_MAX] = $urandom;
                end
                reg_vals[REG_TARGET] = $urandom_range(4000) - 2000;
            end
        endcase
    endtask

    // keep the write enable high across the whole register set
    task automatic program_regs();
        cfg_we <= 1'b1;
        for (int i = 0; i <= REG_TARGET; i++)
        begin
            cfg_index <= 3'(i);
            cfg_data  <= reg_vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_item();
        int          r;
        logic [31:0] meas;
        meas = ($urandom_range(4) == 0) ? $urandom
                                        : reg_vals[REG_TARGET] + $urandom_range(2000) - 1000;
        if ($urandom_range(99) < 4)
        begin
            send_item(1'b1, $urandom, 63'({$urandom, $urandom}));
            return;
        end
        r = $urandom_range(99);
        if (r < 70)
            t = t + $urandom_range(20000);
        else if (r < 80)
            t = t + $urandom_range(999);
        else if (r < 86)
            t = t;
        else if (r < 90)
            t = t - $urandom_range(5000);
        else if (r < 95)
            t = t + {8'($urandom_range(255)), $urandom};
        else
            t = 63'({$urandom, $urandom});
        send_item(1'b0, meas, t);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        pick_setting(0);
        program_regs();
        t = 63'd1000;
        send_item(1'b0, 32'd0, t);
        send_item(1'b0, 32'd100, t);
        send_item(1'b0, 32'd100, 63'd500);
        t = 63'd1500;
        send_item(1'b0, 32'd200, t);
        t = t + 63'd10000;
        send_item(1'b0, -32'sd50, t);
        t = t + 63'd1000;
        send_item(1'b0, 32'h7FFF_FFFF, t);
        t = t + 63'd1000;
        send_item(1'b0, 32'h8000_0000, t);
        send_item(1'b1, 32'd0, 63'd0);
        send_item(1'b1, 32'hFFFF_FFFF, {63{1'b1}});
        send_item(1'b0, 32'h8000_0000, {63{1'b1}});
        send_item(1'b0, 32'd5, 63'd0);
        send_item(1'b1, 32'd0, 63'd0);
        t = 63'd0;
        send_item(1'b0, 32'd500, t);
        // millisecond count wrapping to a small, a negative and a minus-one value
        t = t + 63'h3E8_0000_1388;
        send_item(1'b0, 32'd400, t);
        t = t + 63'h1F4_0000_0000;
        send_item(1'b0, 32'd300, t);
        t = t + 63'h3E7_FFFF_FC18;
        send_item(1'b0, 32'd600, t);
        t = t + 63'd1000;
        send_item(1'b0, 32'd500, t);

        wait_idle();
        pick_setting(1);
        program_regs();
        send_item(1'b1, 32'd0, t);
        send_item(1'b0, 32'd0, t);
        t = t + 63'd2000;
        send_item(1'b0, 32'h7FFF_FFFF, t);
        t = t + 63'd1000000;
        send_item(1'b0, 32'h8000_0000, t);
        t = t + 63'd1;
        send_item(1'b0, 32'd0, t);

        wait_idle();
        pick_setting(2);
        program_regs();
        t = t + 63'd3000;
        send_item(1'b0, 32'd10, t);
        t = t + 63'd4000;
        send_item(1'b0, -32'sd10, t);
        send_item(1'b0, 32'd0, t);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            pick_setting(p);
            program_regs();
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 47; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 47; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_idle();
                random_item();
            end
        end

        wait_idle();
        $display("covered %0d items including %0d restarts under %0d register settings",
                 items_sent, restarts, settings);
        $display("and four handshake profiles; %0d results compared", checked);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
